// File: src/itb_pkg.sv
// ----------------------------------------------------------------------------
// itb_pkg
// Shared types and constants of the interval timer bank.
// ----------------------------------------------------------------------------
package itb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int CNT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_START   = 3'd1,
        REQ_STOP    = 3'd2,
        REQ_STOPALL = 3'd3,
        REQ_CHECK   = 3'd4,
        REQ_QUERY   = 3'd5,
        REQ_SCAN    = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_READ,
        ST_EVAL,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_RESP
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB1
    } t_alu_op;

    typedef struct packed {
        logic [31:0] sum;
        logic        lt;
    } t_alu_res;

    typedef struct packed {
        logic               expired;
        logic               on;
        logic               running;
        logic signed [31:0] remaining;
        logic               found;
        logic [3:0]         found_index;
    } t_res;

endpackage

// File: src/itb_if.sv
// ----------------------------------------------------------------------------
// itb_if
// Request and result channels of the interval timer bank.
// ----------------------------------------------------------------------------
interface itb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [3:0]  timer_index;
    logic [23:0] duration_secs;

    modport source (output valid, output req_type, output timer_index,
                    output duration_secs, input ready);
    modport sink   (input valid, input req_type, input timer_index,
                    input duration_secs, output ready);
endinterface

interface itb_res_if;
    logic               valid;
    logic               ready;
    logic               expired_flag;
    logic               timer_on;
    logic               timer_running;
    logic signed [31:0] remaining_secs;
    logic               found_flag;
    logic [3:0]         found_index;

    modport source (output valid, output expired_flag, output timer_on,
                    output timer_running, output remaining_secs,
                    output found_flag, output found_index, input ready);
    modport sink   (input valid, input expired_flag, input timer_on,
                    input timer_running, input remaining_secs,
                    input found_flag, input found_index, output ready);
endinterface

// File: src/itb_ram.sv
// ----------------------------------------------------------------------------
// itb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/itb_alu.sv
// ----------------------------------------------------------------------------
// itb_alu
// Shared adder: saturating unsigned add, or a - b + 1 saturated to int32
// with a "strictly below" flag.
// ----------------------------------------------------------------------------
module itb_alu (
    input  itb_pkg::t_alu_op  i_op,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output itb_pkg::t_alu_res o_res
);
    import itb_pkg::*;

    logic [33:0] bx;
    logic [33:0] cin;
    logic [33:0] s;

    always_comb begin
        if (i_op == ALU_SUB1) begin
            // ~b + 2 gives 1 - b in two's complement
            bx  = ~{2'b00, i_b};
            cin = 34'd2;
        end else begin
            bx  = {2'b00, i_b};
            cin = 34'd0;
        end
        s = {2'b00, i_a} + bx + cin;
    end

    always_comb begin
        if (i_op == ALU_SUB1) begin
            if (s[33] && (s[32:31] != 2'b11)) begin
                o_res.sum = 32'h8000_0000;
            end else if (!s[33] && (s[32:31] != 2'b00)) begin
                o_res.sum = 32'h7FFF_FFFF;
            end else begin
                o_res.sum = s[31:0];
            end
            // a < b exactly when a - b + 1 <= 0
            o_res.lt = s[33] || (s == 34'd0);
        end else begin
            o_res.sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
            o_res.lt  = 1'b0;
        end
    end

endmodule

// File: src/interval_timer_bank.sv
// ----------------------------------------------------------------------------
// interval_timer_bank
// Bank of one-shot second timers sharing one saturating seconds counter.
//
// One request item in on i_req, exactly one result item out on o_res, both
// valid/ready channels. i_req.ready is high only while the sequencer idles,
// so one request is worked on at a time. After acceptance the sequencer
// runs tick, start and stop through its execute state, stop all through its
// clear state, check and query of an armed timer through read and evaluate,
// and scan through scan read and scan evaluate; any other request goes
// straight to the response state, which registers the result. The next
// request can be taken as soon as the result shows.
// The expiry times sit in a RAM with registered read behind one adder; the
// scan reads and checks timers in turn up to a hit; stop all clears one
// armed bit per cycle. The result register lets the next request be taken
// while a result waits; a stalled receiver holds the sequencer in its
// response state only once a second result is ready. Reset clears the
// counter, all armed bits and the result valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_timer_bank (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itb_req_if.sink   i_req,
    itb_res_if.source o_res
);
    import itb_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    t_req                    r_kind;
    logic [3:0]              r_idx;
    logic                    r_ok;
    logic [23:0]             r_dur;
    logic [CNT_W-1:0]        r_cnt;
    logic [31:0]             r_now;
    logic [NUM_TIMERS-1:0]   r_armed;
    t_res                    r_res;
    t_res                    r_out;
    logic                    r_out_valid;

    logic                    accept;
    logic                    in_ok;
    logic [CNT_W-1:0]        in_addr;
    logic [CNT_W-1:0]        idx_addr;
    logic                    cnt_last;
    logic                    out_free;
    logic                    scan_hit;

    logic                    c_in_ready;
    logic                    c_ram_we;
    logic                    c_load_out;
    t_alu_op                 c_alu_op;
    logic [31:0]             alu_a;
    logic [31:0]             alu_b;
    t_alu_res                alu_res;
    logic [CNT_W-1:0]        ram_raddr;
    logic [31:0]             ram_rdata;

    assign accept   = i_req.valid && c_in_ready;
    assign in_ok    = ({28'd0, i_req.timer_index} < 32'(NUM_TIMERS));
    assign in_addr  = CNT_W'(i_req.timer_index);
    assign idx_addr = CNT_W'(r_idx);
    assign cnt_last = (r_cnt == CNT_W'(NUM_TIMERS - 1));
    assign out_free = !r_out_valid || o_res.ready;
    assign scan_hit = r_armed[r_cnt] && alu_res.lt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_req'(i_req.req_type))
                        REQ_TICK, REQ_START, REQ_STOP: n_state = ST_EXEC;
                        REQ_STOPALL:                   n_state = ST_CLEAR;
                        REQ_CHECK, REQ_QUERY: begin
                            n_state = (in_ok && r_armed[in_addr]) ? ST_READ : ST_RESP;
                        end
                        REQ_SCAN:                      n_state = ST_SCAN_RD;
                        default:                       n_state = ST_RESP;
                    endcase
                end
            end
            ST_EXEC:    n_state = ST_RESP;
            ST_CLEAR:   n_state = cnt_last ? ST_RESP : ST_CLEAR;
            ST_READ:    n_state = ST_EVAL;
            ST_EVAL:    n_state = ST_RESP;
            ST_SCAN_RD: n_state = ST_SCAN_EV;
            ST_SCAN_EV: n_state = (scan_hit || cnt_last) ? ST_RESP : ST_SCAN_RD;
            ST_RESP:    n_state = out_free ? ST_IDLE : ST_RESP;
            default:    n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        c_in_ready = (r_state == ST_IDLE);
        c_ram_we   = (r_state == ST_EXEC) && (r_kind == REQ_START) && r_ok;
        c_load_out = (r_state == ST_RESP) && out_free;
        c_alu_op   = (r_state == ST_EXEC) ? ALU_ADD : ALU_SUB1;
        ram_raddr  = (r_state == ST_SCAN_RD) ? r_cnt : idx_addr;
        if (r_state == ST_EXEC) begin
            alu_a = r_now;
            alu_b = (r_kind == REQ_TICK) ? 32'd1 : {8'd0, r_dur};
        end else begin
            alu_a = ram_rdata;
            alu_b = r_now;
        end
    end

    itb_alu u_alu (
        .i_op  (c_alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    itb_ram #(
        .WIDTH (32),
        .DEPTH (NUM_TIMERS)
    ) u_expiry (
        .i_clk   (i_clk),
        .i_we    (c_ram_we),
        .i_waddr (idx_addr),
        .i_wdata (alu_res.sum),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= 32'd0;
            r_armed     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end
            case (r_state)
                ST_EXEC: begin
                    if (r_kind == REQ_TICK) begin
                        r_now <= alu_res.sum;
                    end else if (r_kind == REQ_START && r_ok) begin
                        r_armed[idx_addr] <= 1'b1;
                    end else if (r_kind == REQ_STOP && r_ok) begin
                        r_armed[idx_addr] <= 1'b0;
                    end
                end
                ST_CLEAR: begin
                    r_armed[r_cnt] <= 1'b0;
                    r_cnt          <= r_cnt + CNT_W'(1);
                end
                ST_EVAL: begin
                    if (r_kind == REQ_CHECK && alu_res.lt) begin
                        r_armed[idx_addr] <= 1'b0;
                    end
                end
                ST_SCAN_EV: begin
                    if (scan_hit) begin
                        r_armed[r_cnt] <= 1'b0;
                    end else if (!cnt_last) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: ;
            endcase
            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= t_req'(i_req.req_type);
            r_idx  <= i_req.timer_index;
            r_ok   <= in_ok;
            r_dur  <= i_req.duration_secs;
            r_res  <= '0;
        end
        if (r_state == ST_EVAL) begin
            if (r_kind == REQ_CHECK) begin
                r_res.expired <= alu_res.lt;
            end else begin
                r_res.on        <= 1'b1;
                r_res.running   <= !alu_res.lt;
                r_res.remaining <= alu_res.sum;
            end
        end
        if (r_state == ST_SCAN_EV && scan_hit) begin
            r_res.found       <= 1'b1;
            r_res.found_index <= 4'(r_cnt);
        end
        if (c_load_out) begin
            r_out <= r_res;
        end
    end

    assign i_req.ready          = c_in_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.expired_flag   = r_out.expired;
    assign o_res.timer_on       = r_out.on;
    assign o_res.timer_running  = r_out.running;
    assign o_res.remaining_secs = r_out.remaining;
    assign o_res.found_flag     = r_out.found;
    assign o_res.found_index    = r_out.found_index;

    // the sequencer takes one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while previous one still in work");

    // seconds counter never goes backwards
    a_now_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_now >= $past(r_now)))
        else $error("seconds counter decreased");

    // a scan hit disarms the timer it reports
    a_scan_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_EV && scan_hit) |=> !r_armed[r_cnt])
        else $error("scanned timer still armed");

    // results are only loaded from the response state
    a_load_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RESP))
        else $error("result shown outside response state");

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for interval_timer_bank. A scoreboard class keeps its
// own copy of the seconds counter, armed bits and expiry times, predicts the
// result of every accepted request and checks the results in order. Directed
// requests come first, then random bursts with random gaps, against a
// receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import itb_pkg::*;

    localparam logic [2:0] REQ_UNKNOWN  = 3'd7;
    localparam int         RANDOM_ITEMS = 1400;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         HOLD_AFTER   = 400;   // requests taken before the long stall
    localparam int         HOLD_CYCLES  = 300;

    typedef struct {
        logic [2:0]  kind;
        logic [3:0]  idx;
        logic [23:0] dur;
    } t_request;

    class timer_bank_tracker;
        logic [31:0]         now_secs = '0;
        bit [NUM_TIMERS-1:0] armed    = '0;
        logic [31:0]         expiry [NUM_TIMERS];
        t_res                pending_results [$];
        int errors        = 0;
        int taken         = 0;
        int checked       = 0;
        int expiries_seen = 0;
        int scan_hits     = 0;
        int queries_on    = 0;

        function bit fire_timer(int i);
            if (armed[i] && expiry[i] < now_secs) begin
                armed[i] = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function t_res predict_result(t_request q);
            t_res        r;
            logic [32:0] sum;
            longint      diff;
            bit          in_range;
            r        = '0;
            in_range = int'(q.idx) < NUM_TIMERS;
            case (q.kind)
                REQ_TICK: begin
                    if (now_secs != '1) now_secs = now_secs + 1;
                end
                REQ_START: begin
                    if (in_range) begin
                        sum = {1'b0, now_secs} + {9'b0, q.dur};
                        armed[q.idx]  = 1'b1;
                        expiry[q.idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                end
                REQ_STOP: begin
                    if (in_range) armed[q.idx] = 1'b0;
                end
                REQ_STOPALL: begin
                    armed = '0;
                end
                REQ_CHECK: begin
                    if (in_range) r.expired = fire_timer(int'(q.idx));
                end
                REQ_QUERY: begin
                    if (in_range && armed[q.idx]) begin
                        diff = longint'(expiry[q.idx]) - longint'(now_secs) + 1;
                        if (diff < -64'sd2147483648) diff = -64'sd2147483648;
                        if (diff > 64'sd2147483647)  diff = 64'sd2147483647;
                        r.on        = 1'b1;
                        r.running   = expiry[q.idx] >= now_secs;
                        r.remaining = 32'(diff);
                    end
                end
                REQ_SCAN: begin
                    for (int j = 0; j < NUM_TIMERS; j++) begin
                        if (fire_timer(j)) begin
                            r.found       = 1'b1;
                            r.found_index = 4'(j);
                            break;
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_request(t_request q);
            t_res r;
            r = predict_result(q);
            taken++;
            if (r.expired) expiries_seen++;
            if (r.found)   scan_hits++;
            if (r.on)      queries_on++;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected, expected nothing got %p",
                         $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            compare_field("expired_flag",   want.expired,     got.expired);
            compare_field("timer_on",       want.on,          got.on);
            compare_field("timer_running",  want.running,     got.running);
            compare_field("remaining_secs", want.remaining,   got.remaining);
            compare_field("found_flag",     want.found,       got.found);
            compare_field("found_index",    want.found_index, got.found_index);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    itb_req_if req_if ();
    itb_res_if res_if ();

    interval_timer_bank dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    timer_bank_tracker tracker = new();

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_count, tracker.pending_results.size());
        $display("FAILURE");
        $finish;
    end

    function automatic t_request random_request();
        t_request q;
        int       pick;
        pick = $urandom_range(0, 99);
        if      (pick < 30) q.kind = REQ_TICK;
        else if (pick < 55) q.kind = REQ_START;
        else if (pick < 63) q.kind = REQ_STOP;
        else if (pick < 66) q.kind = REQ_STOPALL;
        else if (pick < 80) q.kind = REQ_CHECK;
        else if (pick < 93) q.kind = REQ_QUERY;
        else if (pick < 99) q.kind = REQ_SCAN;
        else                q.kind = REQ_UNKNOWN;
        q.idx = 4'($urandom_range(0, NUM_TIMERS - 1));
        // short durations so that timers actually run out between ticks
        pick = $urandom_range(0, 99);
        if      (pick < 80) q.dur = 24'($urandom_range(0, 6));
        else if (pick < 95) q.dur = 24'($urandom_range(0, 255));
        else                q.dur = 24'($urandom);
        return q;
    endfunction

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_request(input t_request q);
        req_if.valid         <= 1'b1;
        req_if.req_type      <= q.kind;
        req_if.timer_index   <= q.idx;
        req_if.duration_secs <= q.dur;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        tracker.note_request(q);
    endtask

    task automatic wait_results_drained();
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side: stalls in modes of random length, plus one long hold-off
    initial begin : result_sink
        t_res got;
        int   mode;
        int   mode_left;
        int   hold_left;
        bit   hold_done;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.expired     = res_if.expired_flag;
                got.on          = res_if.timer_on;
                got.running     = res_if.timer_running;
                got.remaining   = res_if.remaining_secs;
                got.found       = res_if.found_flag;
                got.found_index = res_if.found_index;
                tracker.check_result(got);
            end
            if (!hold_done && tracker.taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : request_source
        t_request directed [$];
        int       sent;
        int       burst;
        int       gap;
        bit       paused;

        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_TICK;
        req_if.timer_index   = '0;
        req_if.duration_secs = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // off timer, nothing expired, expiry equal to now, one second past,
        // widest duration, lowest index wins a scan, stop all, unknown kind
        directed.push_back('{REQ_QUERY,   4'd0,  24'd0});
        directed.push_back('{REQ_CHECK,   4'd0,  24'd0});
        directed.push_back('{REQ_SCAN,    4'd0,  24'd0});
        directed.push_back('{REQ_START,   4'd0,  24'd0});
        directed.push_back('{REQ_QUERY,   4'd0,  24'd0});
        directed.push_back('{REQ_CHECK,   4'd0,  24'd0});
        directed.push_back('{REQ_TICK,    4'd0,  24'd0});
        directed.push_back('{REQ_QUERY,   4'd0,  24'd0});
        directed.push_back('{REQ_START,   4'd15, 24'hFF_FFFF});
        directed.push_back('{REQ_QUERY,   4'd15, 24'd0});
        directed.push_back('{REQ_START,   4'd5,  24'd0});
        directed.push_back('{REQ_TICK,    4'd15, 24'hFF_FFFF});
        directed.push_back('{REQ_SCAN,    4'd0,  24'd0});
        directed.push_back('{REQ_SCAN,    4'd0,  24'd0});
        directed.push_back('{REQ_SCAN,    4'd0,  24'd0});
        directed.push_back('{REQ_CHECK,   4'd15, 24'd0});
        directed.push_back('{REQ_STOP,    4'd15, 24'd0});
        directed.push_back('{REQ_QUERY,   4'd15, 24'd0});
        directed.push_back('{REQ_START,   4'd3,  24'd0});
        directed.push_back('{REQ_TICK,    4'd0,  24'd0});
        directed.push_back('{REQ_STOPALL, 4'd0,  24'd0});
        directed.push_back('{REQ_SCAN,    4'd0,  24'd0});
        directed.push_back('{REQ_UNKNOWN, 4'd15, 24'hFF_FFFF});
        directed.push_back('{REQ_START,   4'd9,  24'd0});
        directed.push_back('{REQ_TICK,    4'd0,  24'd0});
        directed.push_back('{REQ_CHECK,   4'd9,  24'd0});
        directed.push_back('{REQ_CHECK,   4'd9,  24'd0});

        @(posedge i_clk);
        foreach (directed[i]) send_request(directed[i]);
        req_if.valid <= 1'b0;
        wait_results_drained();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_request(random_request());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                // let the block and the receiver run completely dry once
                paused = 1'b1;
                req_if.valid <= 1'b0;
                wait_results_drained();
            end else if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_if.valid <= 1'b0;

        wait_results_drained();
        repeat (2 * NUM_TIMERS + 8) @(posedge i_clk);

        $display("%0d requests taken, %0d results checked, seconds counter at %0d",
                 tracker.taken, tracker.checked, tracker.now_secs);
        $display("%0d checks fired, %0d scans found a timer, %0d queries hit an armed timer",
                 tracker.expiries_seen, tracker.scan_hits, tracker.queries_on);
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", tracker.errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
